// ===== rtl/core/sli_pkg.sv =====
// Package for the sorted list block: opcodes, status codes, field widths and
// the command and status structures between controller and datapath.
// No dependencies.
`default_nettype none

package sli_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int OPCODE_W     = 2;
  localparam int STATUS_W     = 2;
  localparam int ENTRY_W      = 5;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DUMP   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic ins;
    logic del;
    logic rot;
    logic clr_idx;
    logic load_op;
    logic load_dump;
    logic load_empty;
  } sli_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic dump_last;
  } sli_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/sli_in_if.sv =====
// Input channel of the sorted list block: valid, ready, opcode and value.
// Depends on sli_pkg.
`default_nettype none

interface sli_in_if;
  logic                                valid;
  logic                                ready;
  logic [sli_pkg::OPCODE_W-1:0]        opcode;
  logic signed [sli_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sli_out_if.sv =====
// Result channel of the sorted list block: valid, ready and the result fields.
// Depends on sli_pkg.
`default_nettype none

interface sli_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sli_pkg::VALUE_W-1:0]  result_value;
  logic [sli_pkg::STATUS_W-1:0]        status;
  logic [sli_pkg::ENTRY_W-1:0]         entry_count;
  logic                                last;

  modport source (output valid, output result_value, output status, output entry_count,
                  output last, input ready);
  modport sink (input valid, input result_value, input status, input entry_count,
                input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sli_datapath.sv =====
// Datapath of the sorted list: the row of entry cells with compare-and-shift
// for insert and delete, rotation for dumps, and the result register.
// Depends on sli_pkg.
`default_nettype none

module sli_datapath #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire sli_pkg::sli_cmd_t                  cmd,
  input  wire logic signed [sli_pkg::VALUE_W-1:0] value,
  output sli_pkg::sli_sts_t                       sts,
  output logic signed [sli_pkg::VALUE_W-1:0]      res_value,
  output logic [sli_pkg::STATUS_W-1:0]            res_status,
  output logic [sli_pkg::ENTRY_W-1:0]             res_count,
  output logic                                    res_last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VW = sli_pkg::VALUE_W;
  localparam int EW = sli_pkg::ENTRY_W;

  logic signed [VW-1:0] cells_r   [CAPACITY];
  logic signed [VW-1:0] cells_nxt [CAPACITY];
  logic [CW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        last_pos;
  logic [CAPACITY-1:0]  gt, hit;
  logic                 full, found;
  logic [sli_pkg::STATUS_W-1:0] op_status;

  assign last_pos = count_r - CW'(1);
  assign full     = (count_r == CW'(CAPACITY));
  assign found    = hit[CAPACITY-1];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i]  = (CW'(i) < count_r) && (value > cells_r[i]);
      hit[i] = (CW'(i) < count_r) && (value == cells_r[i]);
      if (i > 0) begin
        hit[i] = hit[i] | hit[i-1];
      end
    end
  end

  always_comb begin
    cells_nxt = cells_r;
    count_nxt = count_r;
    if (cmd.ins && !full) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!gt[i]) begin
          if (i == 0) begin
            cells_nxt[i] = value;
          end else if (gt[i-1]) begin
            cells_nxt[i] = value;
          end else begin
            cells_nxt[i] = cells_r[i-1];
          end
        end
      end
      count_nxt = count_r + CW'(1);
    end
    if (cmd.del && found) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (hit[i]) begin
          cells_nxt[i] = cells_r[i+1];
        end
      end
      count_nxt = count_r - CW'(1);
    end
    if (cmd.rot) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        cells_nxt[i] = (CW'(i) == last_pos) ? cells_r[0] : cells_r[i+1];
      end
      if (CW'(CAPACITY - 1) == last_pos) begin
        cells_nxt[CAPACITY-1] = cells_r[0];
      end
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clr_idx) begin
      idx_nxt = '0;
    end else if (cmd.rot) begin
      idx_nxt = idx_r + IW'(1);
    end
  end

  always_comb begin
    op_status = sli_pkg::ST_OK;
    if (cmd.ins && full) begin
      op_status = sli_pkg::ST_FULL;
    end else if (cmd.del && !found) begin
      op_status = sli_pkg::ST_NOT_FOUND;
    end
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.dump_last  = (CW'(idx_r) == last_pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    if (cmd.load_op) begin
      res_value  <= value;
      res_status <= op_status;
      res_count  <= EW'(count_nxt);
      res_last   <= 1'b1;
    end else if (cmd.load_dump) begin
      res_value  <= cells_r[0];
      res_status <= sli_pkg::ST_OK;
      res_count  <= EW'(count_r);
      res_last   <= sts.dump_last;
    end else if (cmd.load_empty) begin
      res_value  <= '0;
      res_status <= sli_pkg::ST_EMPTY;
      res_count  <= '0;
      res_last   <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins && !full |=> count_r == $past(count_r) + CW'(1))
    else $error("Insert into a list with room did not add an entry.");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del && found |=> count_r == $past(count_r) - CW'(1))
    else $error("Delete of a stored value did not remove an entry.");

  a_rot_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rot |-> !cmd.ins && !cmd.del && !sts.count_zero)
    else $error("Rotation overlaps an update or runs on an empty list.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sli_ctrl.sv =====
// Controller of the sorted list: accepts words, sequences dumps one entry a
// cycle unless stalled and keeps the result's valid flag. Depends on sli_pkg.
`default_nettype none

module sli_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [sli_pkg::OPCODE_W-1:0]  in_opcode,
  output logic                               in_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  input  wire sli_pkg::sli_sts_t             sts,
  output sli_pkg::sli_cmd_t                  cmd
);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   free;

  assign free      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = free;
        if (in_valid && free) begin
          case (in_opcode)
            sli_pkg::OP_INSERT: begin
              cmd.ins     = 1'b1;
              cmd.load_op = 1'b1;
            end
            sli_pkg::OP_DELETE: begin
              cmd.del     = 1'b1;
              cmd.load_op = 1'b1;
            end
            sli_pkg::OP_DUMP: begin
              if (sts.count_zero) begin
                cmd.load_empty = 1'b1;
              end else begin
                cmd.clr_idx = 1'b1;
                state_nxt   = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (free) begin
          cmd.load_dump = 1'b1;
          cmd.rot       = 1'b1;
          if (sts.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = (cmd.load_op || cmd.load_dump || cmd.load_empty) ? 1'b1
                                                                     : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(cmd.load_op || cmd.load_dump || cmd.load_empty))
    else $error("Result register loaded while a word is still waiting.");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_op, cmd.load_dump, cmd.load_empty}))
    else $error("More than one result source selected.");

  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_idx |=> !in_ready)
    else $error("Input accepted while a dump is in progress.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sorted_list_insert_delete.sv =====
// Sorted list of up to CAPACITY signed 32-bit values held in ascending order.
// Insert and delete are compare-and-shift over all cells at once, so one such
// word is taken every cycle while the result register can drain; the result is
// registered and appears in the cycle after acceptance. A dump clears the
// index, then returns one entry a cycle while the output drains, as the cell
// row rotates back to its original order, and takes no input meanwhile; an
// empty dump returns one word. Unused opcode 3 is taken and ignored.
// Depends on sli_pkg, sli_in_if, sli_out_if, sli_ctrl and sli_datapath.
`default_nettype none

module sorted_list_insert_delete #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sli_in_if.sink     in_ch,
  sli_out_if.source  out_ch
);

  sli_pkg::sli_cmd_t cmd;
  sli_pkg::sli_sts_t sts;

  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sli_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .value      (in_ch.value),
    .sts        (sts),
    .res_value  (out_ch.result_value),
    .res_status (out_ch.status),
    .res_count  (out_ch.entry_count),
    .res_last   (out_ch.last)
  );

endmodule

`default_nettype wire
